>>> design/p1305_pkg.sv
package p1305_pkg;

  localparam int unsigned LimbW = 26;
  localparam int unsigned AccW  = 27;
  localparam int unsigned HmW   = 28;
  localparam int unsigned NLimb = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegRLow   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRHigh  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPadLow = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPadHi  = 2'd3;

  localparam logic [127:0] ClampMask = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  // Job handed from front to back: a padded 130-bit block and flags.
  typedef struct packed {
    logic [129:0] msg;
    logic         absorb;
    logic         last;
  } p1305_job_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StCarry = 4'b0100,
    StFin  = 4'b1000
  } p1305_state_e;

endpackage

>>> design/p1305_front.sv
module p1305_front
  import p1305_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [63:0]  block_low_i,
  input  logic [63:0]  block_high_i,
  input  logic [4:0]   byte_count_i,
  input  logic         last_i,
  output logic         job_valid_o,
  input  logic         job_take_i,
  output p1305_job_t   job_o
);

  // Two-entry queue between classification and the arithmetic back end.
  p1305_job_t  mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic [4:0]  n;
  logic [127:0] keep, one, data;
  p1305_job_t  job;
  logic        push, pop;

  always_comb begin
    n = (byte_count_i > 5'd16) ? 5'd16 : byte_count_i;
    keep = '1;
    one  = '0;
    if (n < 5'd16) begin
      keep = (128'd1 << {n[3:0], 3'b000}) - 128'd1;
      one  = 128'd1 << {n[3:0], 3'b000};
    end
    data = ({block_high_i, block_low_i} & keep) | one;
    job.msg    = {(n == 5'd16) ? 2'b01 : 2'b00, data};
    job.absorb = (n != 5'd0);
    job.last   = last_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_take_i;
  assign job_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> design/p1305_back.sv
module p1305_back
  import p1305_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         job_valid_i,
  output logic         job_take_o,
  input  p1305_job_t   job_i,
  input  logic [127:0] r_i,
  input  logic [127:0] pad_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [63:0]  tag_low_o,
  output logic [63:0]  tag_high_o
);

  p1305_state_e state_q, state_d;
  logic [AccW-1:0]  acc_q [NLimb];
  logic [HmW-1:0]   hm_q [NLimb];   // h+m limbs, one bit above the accumulator
  logic [63:0]      d_q [NLimb];
  logic [2:0]       row_q;
  logic             last_q;
  logic             ov_q;
  logic [63:0]      tl_q, th_q;
  logic [LimbW-1:0] rl [NLimb];
  logic [28:0]      sl [NLimb];
  logic [129:0]     rc;
  logic [HmW-1:0]   hsel;
  logic [63:0]      prod [NLimb];
  logic [63:0]      c0, c1, c2, c3, c4, c5;
  logic [63:0]      e0, e1, e2, e3;
  logic [63:0]      f0;
  logic [130:0]     hv;
  logic [129:0]     hx, gv;
  logic [130:0]     gsum;
  logic [127:0]     fin;

  assign rc = {2'b00, r_i & ClampMask};
  always_comb begin
    for (int i = 0; i < NLimb; i++) begin
      rl[i] = rc[26*i +: LimbW];
      sl[i] = {3'b000, rl[i]} + {1'b0, rl[i], 2'b00};
    end
  end

  // One multiplier row per cycle: h[row] times each limb of r (or 5r).
  always_comb begin
    hsel = hm_q[row_q];
    for (int j = 0; j < NLimb; j++) begin
      if (j >= row_q) prod[j] = 64'(hsel) * 64'(rl[j - row_q]);
      else            prod[j] = 64'(hsel) * 64'(sl[NLimb + j - row_q]);
    end
  end

  always_comb begin
    c0 = d_q[0];
    e0 = d_q[1] + (c0 >> 26);
    e1 = d_q[2] + (e0 >> 26);
    e2 = d_q[3] + (e1 >> 26);
    e3 = d_q[4] + (e2 >> 26);
    c1 = e3 >> 26;
    f0 = 64'(c0[25:0]) + c1 * 64'd5;
    c2 = 64'(e0[25:0]) + (f0 >> 26);
    c3 = e1; c4 = e2; c5 = e3;
  end

  // Finish: fold bit 130 back in, subtract p if h >= p, then add the pad.
  always_comb begin
    hv = 131'(acc_q[0]) + (131'(acc_q[1]) << 26) + (131'(acc_q[2]) << 52)
       + (131'(acc_q[3]) << 78) + (131'(acc_q[4]) << 104);
    hx   = hv[129:0] + (hv[130] ? 130'd5 : 130'd0);
    gsum = 131'(hx) + 131'd5;
    gv   = hx;
    if (gsum[130]) gv = gsum[129:0];
    fin = gv[127:0] + pad_i;
  end

  assign job_take_o  = (state_q == StIdle) && !(ov_q && out_stall_i);
  assign out_valid_o = ov_q;
  assign tag_low_o   = tl_q;
  assign tag_high_o  = th_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (job_valid_i && job_take_o)
                state_d = job_i.absorb ? StMul : (job_i.last ? StFin : StIdle);
      StMul:   if (row_q == 3'd4) state_d = StCarry;
      StCarry: state_d = last_q ? StFin : StIdle;
      StFin:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && job_valid_i && job_take_o) begin
      for (int i = 0; i < NLimb; i++)
        hm_q[i] <= HmW'(acc_q[i]) + HmW'(job_i.msg[26*i +: LimbW]);
      for (int i = 0; i < NLimb; i++) d_q[i] <= '0;
    end else if (state_q == StMul) begin
      for (int j = 0; j < NLimb; j++) d_q[j] <= d_q[j] + prod[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      row_q   <= '0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
      tl_q    <= '0;
      th_q    <= '0;
      for (int i = 0; i < NLimb; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StFin) ov_q <= 1'b1;
      else if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          row_q <= '0;
          if (job_valid_i && job_take_o) last_q <= job_i.last;
        end
        StMul: row_q <= (row_q == 3'd4) ? 3'd0 : row_q + 3'd1;
        StCarry: begin
          acc_q[0] <= AccW'(f0[25:0]);
          acc_q[1] <= AccW'(c2[26:0]);
          acc_q[2] <= AccW'(c3[25:0]);
          acc_q[3] <= AccW'(c4[25:0]);
          acc_q[4] <= AccW'(c5[25:0]);
        end
        StFin: begin
          tl_q <= fin[63:0];
          th_q <= fin[127:64];
          for (int i = 0; i < NLimb; i++) acc_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/poly1305_mac_unit.sv
// poly1305_mac_unit: Poly1305 authenticator, key in four config registers.
// Flow: an absorbing item passes the queue, five multiply rows and a carry step; a last item
//   then goes through the finish step to the tag. An empty last item goes straight to finish.
// The back end takes a new item only once idle again, after the previous item's rows, carry and
//   any finish; a stalled tag holds off the next take. A two-entry queue lets the front accept while the back works.
// Reset (async, active low) clears keys, accumulator, queue and output valid.
module poly1305_mac_unit
  import p1305_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic [4:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] tag_low_o,
  output logic [63:0] tag_high_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] r_low_q, r_high_q, pad_low_q, pad_high_q;
  logic        job_valid, job_take;
  p1305_job_t  job;

  assign cfg_ready_o = 1'b1;

  // Key registers; r is clamped where it is used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_low_q <= '0; r_high_q <= '0; pad_low_q <= '0; pad_high_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRLow:   r_low_q    <= cfg_data_i;
        RegRHigh:  r_high_q   <= cfg_data_i;
        RegPadLow: pad_low_q  <= cfg_data_i;
        RegPadHi:  pad_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  p1305_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .block_low_i, .block_high_i, .byte_count_i, .last_i,
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .job_o       (job)
  );

  p1305_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_i       (job),
    .r_i         ({r_high_q, r_low_q}),
    .pad_i       ({pad_high_q, pad_low_q}),
    .out_valid_o, .out_stall_i, .tag_low_o, .tag_high_o
  );

endmodule

>>> design/p1305_checker.sv
module p1305_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] tag_low_o,
  input logic        cfg_ready_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tag_low_o))
    else $error("tag dropped under stall");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config not ready");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |=> !$rose(out_valid_o))
    else $error("tags too close");

endmodule

bind poly1305_mac_unit p1305_checker u_chk (.*);

>>> sim/tb_poly1305_mac_unit.sv
module tb_poly1305_mac_unit;
  import p1305_pkg::*;

  // Field mask for one 26-bit limb.
  localparam logic [63:0] Limb26 = 64'h3ff_ffff;
  localparam logic [63:0] Limb27 = 64'h7ff_ffff;
  // Worst case per item: sender gap, block latency, receiver stall; taken many times over.
  localparam int unsigned CycleLimit = 400000;

  // Scoreboard: owns the key copy, the accumulator copy and the queue of pending tags.
  class tag_scoreboard;
    logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [63:0] acc [5];
    logic [127:0] pending_tags[$];
    int unsigned mismatches;
    int unsigned tags_seen;

    function void clear();
      key_r_lo = '0; key_r_hi = '0; key_s_lo = '0; key_s_hi = '0;
      foreach (acc[i]) acc[i] = '0;
      pending_tags.delete();
      mismatches = 0;
      tags_seen = 0;
    endfunction

    function void write_key(logic [1:0] idx, logic [63:0] data);
      case (idx)
        RegRLow:   key_r_lo = data;
        RegRHigh:  key_r_hi = data;
        RegPadLow: key_s_lo = data;
        RegPadHi:  key_s_hi = data;
        default: ;
      endcase
    endfunction

    // h = (h + m) * clamp(r) mod 2^130-5, partially reduced like the block.
    function void mul_block(logic [63:0] lo, logic [63:0] hi, logic [63:0] top);
      logic [63:0] r0, r1, r2, r3, r4, s1, s2, s3, s4;
      logic [63:0] h0, h1, h2, h3, h4, d0, d1, d2, d3, d4, c;
      r0 = key_r_lo & 64'h03ff_ffff;
      r1 = (key_r_lo >> 26) & 64'h03ff_ff03;
      r2 = ((key_r_lo >> 52) | (key_r_hi << 12)) & 64'h03ff_c0ff;
      r3 = (key_r_hi >> 14) & 64'h03f0_3fff;
      r4 = (key_r_hi >> 40) & 64'h000f_ffff;
      s1 = r1 * 5; s2 = r2 * 5; s3 = r3 * 5; s4 = r4 * 5;
      h0 = acc[0] + (lo & Limb26);
      h1 = acc[1] + ((lo >> 26) & Limb26);
      h2 = acc[2] + (((lo >> 52) | (hi << 12)) & Limb26);
      h3 = acc[3] + ((hi >> 14) & Limb26);
      h4 = acc[4] + ((hi >> 40) | top);
      d0 = h0 * r0 + h1 * s4 + h2 * s3 + h3 * s2 + h4 * s1;
      d1 = h0 * r1 + h1 * r0 + h2 * s4 + h3 * s3 + h4 * s2;
      d2 = h0 * r2 + h1 * r1 + h2 * r0 + h3 * s4 + h4 * s3;
      d3 = h0 * r3 + h1 * r2 + h2 * r1 + h3 * r0 + h4 * s4;
      d4 = h0 * r4 + h1 * r3 + h2 * r2 + h3 * r1 + h4 * r0;
      c = d0 >> 26; h0 = d0 & Limb26;
      d1 += c; c = d1 >> 26; h1 = d1 & Limb26;
      d2 += c; c = d2 >> 26; h2 = d2 & Limb26;
      d3 += c; c = d3 >> 26; h3 = d3 & Limb26;
      d4 += c; c = d4 >> 26; h4 = d4 & Limb26;
      h0 += c * 5; c = h0 >> 26; h0 &= Limb26;
      h1 += c;
      acc[0] = h0 & Limb27; acc[1] = h1 & Limb27; acc[2] = h2 & Limb27;
      acc[3] = h3 & Limb27; acc[4] = h4 & Limb27;
    endfunction

    // Full reduction, add the pad, clear h.
    function logic [127:0] make_tag();
      logic [63:0] h0, h1, h2, h3, h4, g0, g1, g2, g3, g4, c, lo, hi, sum;
      h0 = acc[0]; h1 = acc[1]; h2 = acc[2]; h3 = acc[3]; h4 = acc[4];
      c = h0 >> 26; h0 &= Limb26;
      h1 += c; c = h1 >> 26; h1 &= Limb26;
      h2 += c; c = h2 >> 26; h2 &= Limb26;
      h3 += c; c = h3 >> 26; h3 &= Limb26;
      h4 += c; c = h4 >> 26; h4 &= Limb26;
      h0 += c * 5; c = h0 >> 26; h0 &= Limb26;
      h1 += c;
      g0 = h0 + 5; c = g0 >> 26; g0 &= Limb26;
      g1 = h1 + c; c = g1 >> 26; g1 &= Limb26;
      g2 = h2 + c; c = g2 >> 26; g2 &= Limb26;
      g3 = h3 + c; c = g3 >> 26; g3 &= Limb26;
      g4 = h4 + c;
      if (g4 >= (64'd1 << 26)) begin
        h0 = g0; h1 = g1; h2 = g2; h3 = g3; h4 = g4 - (64'd1 << 26);
      end
      lo = h0 | (h1 << 26) | (h2 << 52);
      hi = (h2 >> 12) | (h3 << 14) | (h4 << 40);
      sum = lo + key_s_lo;
      c = (sum < lo) ? 64'd1 : 64'd0;
      foreach (acc[i]) acc[i] = '0;
      return {hi + key_s_hi + c, sum};
    endfunction

    function void note_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic fin);
      int unsigned n;
      n = (cnt > 16) ? 16 : cnt;
      if (n == 16) begin
        mul_block(lo, hi, 64'd1 << 24);
      end else if (n != 0) begin
        if (n < 8) begin
          lo &= (64'd1 << (8 * n)) - 1;
          lo |= 64'd1 << (8 * n);
          hi = '0;
        end else if (n == 8) begin
          hi = 64'd1;
        end else begin
          hi &= (64'd1 << (8 * (n - 8))) - 1;
          hi |= 64'd1 << (8 * (n - 8));
        end
        mul_block(lo, hi, '0);
      end
      if (fin) pending_tags.push_back(make_tag());
    endfunction

    function void check_tag(logic [63:0] lo, logic [63:0] hi);
      logic [127:0] want;
      tags_seen++;
      if (pending_tags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tag %h_%h", hi, lo);
        return;
      end
      want = pending_tags.pop_front();
      if (want[63:0] !== lo || want[127:64] !== hi) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tag mismatch: want %h_%h got %h_%h", want[127:64], want[63:0], hi, lo);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] block_low_i = '0;
  logic [63:0] block_high_i = '0;
  logic [4:0]  byte_count_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] tag_low_o, tag_high_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  tag_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned blocks_sent = 0;
  int unsigned key_sets = 0;
  // Cleared during long bursts so both sides run flat out.
  bit idle_enable = 1'b1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  poly1305_mac_unit u_dut (.*);

  // Watchdog: counts cycles and ends a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[poly1305_mac_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, tags checked on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_tag(tag_low_o, tag_high_o);
      out_stall_i <= idle_enable && ($urandom_range(99) < 18);
    end
  end

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_key(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_key(idx, data);
  endtask

  // Drive one block item; a random gap goes before it. Valid stays high afterwards.
  task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic fin);
    while (idle_enable && ($urandom_range(99) < 18)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    block_low_i  <= lo;
    block_high_i <= hi;
    byte_count_i <= cnt;
    last_i       <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_block(lo, hi, cnt, fin);
    blocks_sent++;
  endtask

  // Hold the sender until every tag is back, then let queued blocks finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_tags.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_key(logic [63:0] rl, logic [63:0] rh, logic [63:0] sl, logic [63:0] sh);
    drain();
    write_key(RegRLow, rl);
    write_key(RegRHigh, rh);
    write_key(RegPadLow, sl);
    write_key(RegPadHi, sh);
    cfg_valid_i <= 1'b0;
    key_sets++;
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // Mostly well-formed messages: full blocks, then a final block of random length (empty, short or full).
  task automatic send_message();
    int unsigned nblk;
    logic [4:0] cnt;
    nblk = $urandom_range(4);
    repeat (nblk) begin
      cnt = ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'd16;
      send_block(rand64(), rand64(), cnt, 1'b0);
    end
    cnt = 5'($urandom_range(31));
    send_block(rand64(), rand64(), cnt, 1'b1);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero key first (all-zero r), empty message tag equals pad.
    send_block('0, '0, 5'd0, 1'b1);
    load_key(64'h0, 64'h0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    send_block('0, '0, 5'd0, 1'b1);
    send_block('1, '1, 5'd16, 1'b1);
    // All-ones r, so clamping matters; pad wraps mod 2^128.
    load_key('1, '1, '1, '1);
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd16, 1'b1);
    for (int n = 1; n < 16; n++) send_block('1, '1, 5'(n), n[0]);
    send_block('1, '1, 5'd31, 1'b1);
    send_block('0, '0, 5'd17, 1'b0);
    send_block('0, '0, 5'd0, 1'b1);
    // Fixed vector: two full blocks and a two-byte final block.
    load_key(64'h33d4_5ac3_8085_d685, 64'ha806_d542_fe52_4101,
             64'hf5ac_c39c_3af7_94de, 64'h1bf5_4941_aff6_bf4a);
    send_block(64'h7247_6f72_6870_7943, 64'h6f46_2063_6968_7061, 5'd16, 1'b0);
    send_block(64'h6552_2068_6372_6165, 64'h4720_6863_7261_6573, 5'd16, 1'b0);
    send_block(64'h0000_0000_0000_7075, 64'h0, 5'd2, 1'b1);

    // Random: several keys, one burst with no idling.
    while (blocks_sent < 550) begin
      if ($urandom_range(39) == 0) load_key(rand64(), rand64(), rand64(), rand64());
      idle_enable = !(blocks_sent >= 250 && blocks_sent < 330);
      if ($urandom_range(9) == 0)
        send_block(rand64(), rand64(), 5'($urandom_range(31)), 1'($urandom_range(1)));
      else
        send_message();
    end
    idle_enable = 1'b1;
    load_key('1, '0, '0, '1);
    send_message();
    drain();

    $display("%0d blocks, %0d tags checked, %0d key loads", blocks_sent, sb.tags_seen,
             key_sets);
    if (sb.mismatches == 0 && sb.pending_tags.size() == 0) begin
      $display("[poly1305_mac_unit] OK");
    end else begin
      $display("%0d mismatches, %0d tags missing", sb.mismatches, sb.pending_tags.size());
      $display("[poly1305_mac_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/p1305_pkg.sv
design/p1305_front.sv
design/p1305_back.sv
design/poly1305_mac_unit.sv
design/p1305_checker.sv
sim/tb_poly1305_mac_unit.sv
